// File: src/etm_pkg.sv
// Shared fixed-point types, latencies and the rounded Q30 product for the matrix builder.
package etm_pkg;

  // Angle fields carry this many significant bits of a turn.
  localparam int ANGLE_BITS = 16;

  // Working Q30 word: two's complement, headroom for values up to about +/-8.
  localparam int Q_W = 34;
  typedef logic signed [Q_W-1:0] q_t;
  typedef q_t vec_t [3];
  typedef q_t mat_t [3][3];

  // Result field formats.
  typedef logic signed [23:0] ent_t;
  typedef logic signed [31:0] pos_t;

  localparam q_t Q30_ONE = 34'sd1073741824;

  // Register stages of each unit.
  localparam int LAT_SC = 22;
  localparam int LAT_AR = 3;
  localparam int LAT_MM = 2;
  localparam int LAT_AF = 2;

  // Q30 x Q30 product, rounded half up.
  function automatic q_t mul_q30(input q_t a, input q_t b);
    logic signed [2*Q_W-1:0] prod;
    logic signed [2*Q_W-1:0] shifted;
    prod    = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(64'sd536870912);
    shifted = prod >>> 30;
    return shifted[Q_W-1:0];
  endfunction

endpackage

// File: src/etm_sincos.sv
// Pipelined sine and cosine of a fraction of a turn, Q30 results.
module etm_sincos (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  logic [15:0]   angle,
  output logic          vld_out,
  output etm_pkg::q_t   sin_val,
  output etm_pkg::q_t   cos_val
);

  localparam int Lat = etm_pkg::LAT_SC;
  localparam int Steps = 6;
  localparam etm_pkg::q_t HalfPi = 34'sd1686629713;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  typedef struct packed {
    etm_pkg::q_t th;
    etm_pkg::q_t t2;
    quad_t       quad;
  } ctx_t;

  // Horner divisors; sine lane skips its first slot.
  function automatic int unsigned horner_div(input int lane, input int slot);
    int unsigned d;
    d = 1;
    if (lane == 0) begin
      case (slot)
        1: d = 110;
        2: d = 72;
        3: d = 42;
        4: d = 20;
        5: d = 6;
        default: d = 1;
      endcase
    end else begin
      case (slot)
        0: d = 132;
        1: d = 90;
        2: d = 56;
        3: d = 30;
        4: d = 12;
        5: d = 2;
        default: d = 1;
      endcase
    end
    return d;
  endfunction

  logic [Lat-1:0] vld_r;
  logic [etm_pkg::ANGLE_BITS-3:0] frac;
  etm_pkg::q_t x;
  etm_pkg::q_t th1_r;
  quad_t quad1_r;
  ctx_t ctx_r [3*Steps+1];
  etm_pkg::q_t acc [2][Steps+1];
  etm_pkg::q_t sv_r, cv_r;
  quad_t quadf_r;
  etm_pkg::q_t sin_r, cos_r;

  assign frac = angle[etm_pkg::ANGLE_BITS-3:0];
  assign x = etm_pkg::q_t'(frac) <<< (32 - etm_pkg::ANGLE_BITS);

  assign acc[0][0] = etm_pkg::Q30_ONE;
  assign acc[1][0] = etm_pkg::Q30_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], vld_in};
    end
  end

  // Angle in radians and its square.
  always_ff @(posedge clk) begin
    th1_r    <= etm_pkg::mul_q30(x, HalfPi);
    quad1_r  <= quad_t'(angle[etm_pkg::ANGLE_BITS-1 -: 2]);
    ctx_r[0] <= '{th: th1_r, t2: etm_pkg::mul_q30(th1_r, th1_r), quad: quad1_r};
    for (int j = 0; j < 3*Steps; j++) begin
      ctx_r[j+1] <= ctx_r[j];
    end
  end

  // Each slot: product, reciprocal estimate, correction and update.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < Steps; k++) begin : g_slot
      if (l == 0 && k == 0) begin : g_pass
        assign acc[l][k+1] = acc[l][k];
      end else begin : g_step
        localparam int unsigned D = horner_div(l, k);
        localparam logic [31:0] M = 32'((64'd1 << 32) / D);
        etm_pkg::q_t p_r;
        logic [31:0] pd_r, q0_r;
        logic        neg_r;
        logic [39:0] back, rem;
        logic [31:0] quot;
        etm_pkg::q_t acc_r;

        always_comb begin
          back = 40'(q0_r) * 40'(D);
          rem  = 40'(pd_r) - back;
          quot = q0_r + 32'(rem >= 40'(D));
          if (neg_r) begin
            quot = '0;
          end
        end

        always_ff @(posedge clk) begin
          p_r   <= etm_pkg::mul_q30(ctx_r[3*k].t2, acc[l][k]);
          pd_r  <= p_r[31:0];
          neg_r <= p_r[etm_pkg::Q_W-1];
          q0_r  <= 32'((64'(p_r[31:0]) * 64'(M)) >> 32);
          acc_r <= etm_pkg::Q30_ONE - etm_pkg::q_t'({2'b00, quot});
        end

        assign acc[l][k+1] = acc_r;
      end
    end
  end

  // Close the sine series and fold the quadrant in.
  always_ff @(posedge clk) begin
    sv_r    <= etm_pkg::mul_q30(ctx_r[3*Steps].th, acc[0][Steps]);
    cv_r    <= acc[1][Steps];
    quadf_r <= ctx_r[3*Steps].quad;
    case (quadf_r)
      QUAD_I: begin
        sin_r <= sv_r;
        cos_r <= cv_r;
      end
      QUAD_II: begin
        sin_r <= cv_r;
        cos_r <= -sv_r;
      end
      QUAD_III: begin
        sin_r <= -sv_r;
        cos_r <= -cv_r;
      end
      default: begin
        sin_r <= -cv_r;
        cos_r <= sv_r;
      end
    endcase
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;
  assign vld_out = vld_r[Lat-1];

endmodule

// File: src/etm_axisrot.sv
// Three-stage rotation matrix about a unit axis from its sine and cosine.
module etm_axisrot (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  etm_pkg::vec_t axis,
  input  etm_pkg::q_t   s,
  input  etm_pkg::q_t   c,
  output logic          vld_out,
  output etm_pkg::mat_t rot
);

  localparam int Lat = etm_pkg::LAT_AR;

  logic [Lat-1:0] vld_r;
  etm_pkg::mat_t kmat;
  etm_pkg::mat_t uu_r, sk_r, ou_r, sk2_r, m_r;
  etm_pkg::q_t omc_r, c_r, c2_r;

  // Cross-product matrix of the axis.
  always_comb begin
    kmat[0][0] = '0;       kmat[0][1] = -axis[2]; kmat[0][2] = axis[1];
    kmat[1][0] = axis[2];  kmat[1][1] = '0;       kmat[1][2] = -axis[0];
    kmat[2][0] = -axis[1]; kmat[2][1] = axis[0];  kmat[2][2] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    omc_r <= etm_pkg::Q30_ONE - c;
    c_r   <= c;
    c2_r  <= c_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        uu_r[i][j]  <= etm_pkg::mul_q30(axis[i], axis[j]);
        sk_r[i][j]  <= etm_pkg::mul_q30(s, kmat[i][j]);
        ou_r[i][j]  <= etm_pkg::mul_q30(omc_r, uu_r[i][j]);
        sk2_r[i][j] <= sk_r[i][j];
        m_r[i][j]   <= ((i == j) ? c2_r : '0) + ou_r[i][j] + sk2_r[i][j];
      end
    end
  end

  assign rot = m_r;
  assign vld_out = vld_r[Lat-1];

endmodule

// File: src/etm_matmul.sv
// Two-stage 3x3 Q30 matrix product, one rounding per entry.
module etm_matmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  etm_pkg::mat_t a,
  input  etm_pkg::mat_t b,
  output logic          vld_out,
  output etm_pkg::mat_t p
);

  localparam int Lat = etm_pkg::LAT_MM;
  localparam int PW = 2*etm_pkg::Q_W;

  logic [Lat-1:0] vld_r;
  logic signed [PW-1:0] pr_r [3][3][3];
  logic signed [PW+1:0] sum;
  logic signed [PW+1:0] sh;
  etm_pkg::mat_t p_next, p_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int l = 0; l < 3; l++) begin
          pr_r[i][j][l] <= PW'(a[i][l]) * PW'(b[l][j]);
        end
      end
    end
    p_r <= p_next;
  end

  always_comb begin
    sum = '0;
    sh  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = (PW+2)'(pr_r[i][j][0]) + (PW+2)'(pr_r[i][j][1]) + (PW+2)'(pr_r[i][j][2])
              + (PW+2)'(64'sd536870912);
        sh  = sum >>> 30;
        p_next[i][j] = sh[etm_pkg::Q_W-1:0];
      end
    end
  end

  assign p = p_r;
  assign vld_out = vld_r[Lat-1];

endmodule

// File: src/etm_affine.sv
// Scales the rotation columns, forms the translation column and saturates the result.
module etm_affine (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  etm_pkg::mat_t rot,
  input  etm_pkg::ent_t scale [3],
  input  etm_pkg::pos_t move [3],
  input  logic          order,
  output logic          vld_out,
  output etm_pkg::ent_t m_out [3][3],
  output etm_pkg::pos_t t_out [3]
);

  localparam int Lat = etm_pkg::LAT_AF;
  localparam int SW = etm_pkg::Q_W + 24;
  localparam int TW = etm_pkg::Q_W + 32;

  logic [Lat-1:0] vld_r;
  logic signed [SW-1:0] ps_r [3][3];
  logic signed [TW-1:0] pt_r [3][3];
  etm_pkg::pos_t mv_r [3];
  logic ord_r;
  logic signed [SW-1:0] rs;
  logic signed [TW+1:0] ts;
  etm_pkg::ent_t m_next [3][3];
  etm_pkg::pos_t t_next [3];
  etm_pkg::ent_t m_r [3][3];
  etm_pkg::pos_t t_r [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ps_r[i][j] <= SW'(rot[i][j]) * SW'(scale[j]);
        pt_r[i][j] <= TW'(rot[i][j]) * TW'(move[j]);
      end
      mv_r[i] <= move[i];
    end
    ord_r <= order;
    m_r   <= m_next;
    t_r   <= t_next;
  end

  // Round half up, then clamp to the field range.
  always_comb begin
    rs = '0;
    ts = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rs = (ps_r[i][j] + SW'(64'sd536870912)) >>> 30;
        if (rs > SW'(64'sd8388607)) begin
          m_next[i][j] = 24'sh7FFFFF;
        end else if (rs < SW'(-64'sd8388608)) begin
          m_next[i][j] = 24'sh800000;
        end else begin
          m_next[i][j] = rs[23:0];
        end
      end
      ts = ((TW+2)'(pt_r[i][0]) + (TW+2)'(pt_r[i][1]) + (TW+2)'(pt_r[i][2])
            + (TW+2)'(64'sd536870912)) >>> 30;
      if (!ord_r) begin
        t_next[i] = mv_r[i];
      end else if (ts > (TW+2)'(64'sd2147483647)) begin
        t_next[i] = 32'sh7FFFFFFF;
      end else if (ts < (TW+2)'(-64'sd2147483648)) begin
        t_next[i] = 32'sh80000000;
      end else begin
        t_next[i] = ts[31:0];
      end
    end
  end

  assign m_out = m_r;
  assign t_out = t_r;
  assign vld_out = vld_r[Lat-1];

endmodule

// File: src/euler_trs_matrix_builder.sv
// Top level of the Euler-angle scale-rotate-translate matrix builder.
//
// Takes one item on every clock cycle that start is high; busy stays low, as
// the pipeline never holds. Each item leaves in the order it was taken,
// shown for one cycle with done high; the receiver must take it then.
// The pipeline stages are 22 for the sine/cosine series (six Horner slots of
// three stages each among them), 3 for the axis rotations, 2 for each of
// the two matrix products and 2 for scaling, translation and saturation.
// Angles are fractions of a turn, scales Q8.16, translations Q16.16.
module euler_trs_matrix_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic        [15:0] pitch,
  input  logic        [15:0] yaw,
  input  logic        [15:0] roll,
  input  logic signed [23:0] scale_x,
  input  logic signed [23:0] scale_y,
  input  logic signed [23:0] scale_z,
  input  logic signed [31:0] move_x,
  input  logic signed [31:0] move_y,
  input  logic signed [31:0] move_z,
  input  logic               apply_order,
  output logic signed [23:0] m_r0_c0,
  output logic signed [23:0] m_r0_c1,
  output logic signed [23:0] m_r0_c2,
  output logic signed [23:0] m_r1_c0,
  output logic signed [23:0] m_r1_c1,
  output logic signed [23:0] m_r1_c2,
  output logic signed [23:0] m_r2_c0,
  output logic signed [23:0] m_r2_c1,
  output logic signed [23:0] m_r2_c2,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  // Scale, translation and order wait here until the rotation is ready.
  localparam int SideLat = etm_pkg::LAT_SC + etm_pkg::LAT_AR + 2*etm_pkg::LAT_MM;

  typedef struct packed {
    etm_pkg::ent_t sx;
    etm_pkg::ent_t sy;
    etm_pkg::ent_t sz;
    etm_pkg::pos_t mx;
    etm_pkg::pos_t my;
    etm_pkg::pos_t mz;
    logic          order;
  } side_t;

  logic          accept;
  logic [2:0]    sc_vld;
  etm_pkg::q_t   sp, cp, sy, cy, sr, cr;
  etm_pkg::vec_t up_axis, right_axis, dir_axis;
  logic [2:0]    ar_vld;
  etm_pkg::mat_t ry, rp, rr, rr_d1, rr_d2, tmp, rot;
  logic          mm1_vld, mm2_vld;
  side_t         side_r [SideLat];
  etm_pkg::ent_t af_scale [3];
  etm_pkg::pos_t af_move [3];
  etm_pkg::ent_t af_m [3][3];
  etm_pkg::pos_t af_t [3];

  // Never hold the producer off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  etm_sincos u_sc_pitch (
    .clk(clk), .rst(rst), .vld_in(accept), .angle(pitch),
    .vld_out(sc_vld[0]), .sin_val(sp), .cos_val(cp)
  );

  etm_sincos u_sc_yaw (
    .clk(clk), .rst(rst), .vld_in(accept), .angle(yaw),
    .vld_out(sc_vld[1]), .sin_val(sy), .cos_val(cy)
  );

  etm_sincos u_sc_roll (
    .clk(clk), .rst(rst), .vld_in(accept), .angle(roll),
    .vld_out(sc_vld[2]), .sin_val(sr), .cos_val(cr)
  );

  // Up is +Y; right and the view direction follow the yaw.
  assign up_axis[0]    = '0;
  assign up_axis[1]    = etm_pkg::Q30_ONE;
  assign up_axis[2]    = '0;
  assign right_axis[0] = -sy;
  assign right_axis[1] = '0;
  assign right_axis[2] = -cy;
  assign dir_axis[0]   = cy;
  assign dir_axis[1]   = '0;
  assign dir_axis[2]   = -sy;

  etm_axisrot u_ar_yaw (
    .clk(clk), .rst(rst), .vld_in(&sc_vld), .axis(up_axis), .s(sy), .c(cy),
    .vld_out(ar_vld[0]), .rot(ry)
  );

  etm_axisrot u_ar_pitch (
    .clk(clk), .rst(rst), .vld_in(&sc_vld), .axis(right_axis), .s(sp), .c(cp),
    .vld_out(ar_vld[1]), .rot(rp)
  );

  etm_axisrot u_ar_roll (
    .clk(clk), .rst(rst), .vld_in(&sc_vld), .axis(dir_axis), .s(sr), .c(cr),
    .vld_out(ar_vld[2]), .rot(rr)
  );

  // Pitch applied after yaw.
  etm_matmul u_mm_py (
    .clk(clk), .rst(rst), .vld_in(&ar_vld), .a(rp), .b(ry),
    .vld_out(mm1_vld), .p(tmp)
  );

  // Hold the roll matrix for the first product's two stages.
  always_ff @(posedge clk) begin
    rr_d1 <= rr;
    rr_d2 <= rr_d1;
  end

  etm_matmul u_mm_roll (
    .clk(clk), .rst(rst), .vld_in(mm1_vld), .a(rr_d2), .b(tmp),
    .vld_out(mm2_vld), .p(rot)
  );

  // Delay line for the fields that bypass the rotation stages.
  always_ff @(posedge clk) begin
    side_r[0] <= '{sx: scale_x, sy: scale_y, sz: scale_z,
                   mx: move_x, my: move_y, mz: move_z, order: apply_order};
    for (int k = 0; k < SideLat-1; k++) begin
      side_r[k+1] <= side_r[k];
    end
  end

  assign af_scale[0] = side_r[SideLat-1].sx;
  assign af_scale[1] = side_r[SideLat-1].sy;
  assign af_scale[2] = side_r[SideLat-1].sz;
  assign af_move[0]  = side_r[SideLat-1].mx;
  assign af_move[1]  = side_r[SideLat-1].my;
  assign af_move[2]  = side_r[SideLat-1].mz;

  etm_affine u_affine (
    .clk(clk), .rst(rst), .vld_in(mm2_vld), .rot(rot),
    .scale(af_scale), .move(af_move), .order(side_r[SideLat-1].order),
    .vld_out(done), .m_out(af_m), .t_out(af_t)
  );

  assign m_r0_c0 = af_m[0][0];
  assign m_r0_c1 = af_m[0][1];
  assign m_r0_c2 = af_m[0][2];
  assign m_r1_c0 = af_m[1][0];
  assign m_r1_c1 = af_m[1][1];
  assign m_r1_c2 = af_m[1][2];
  assign m_r2_c0 = af_m[2][0];
  assign m_r2_c1 = af_m[2][1];
  assign m_r2_c2 = af_m[2][2];
  assign out_x   = af_t[0];
  assign out_y   = af_t[1];
  assign out_z   = af_t[2];

endmodule
